[hw/rtl/olm_pkg.sv]
// Shared types, register map and constants for the occupancy line-march block.
package olm_pkg;

  // Default geometry and limits
  localparam int GRID_W_DEF      = 256;
  localparam int GRID_H_DEF      = 256;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int MAX_RING_DEF    = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEARANCE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GOAL_GAP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH  = 3'd6;

  // Register reset values
  localparam logic [30:0] CELL_SIZE_RST    = 31'd3277;
  localparam logic [6:0]  COST_LIMIT_RST   = 7'd50;
  localparam logic [31:0] CLEARANCE_RST    = 32'd6554;
  localparam logic [30:0] MIN_GOAL_GAP_RST = 31'd3277;
  localparam logic [30:0] STEP_LENGTH_RST  = 31'd3277;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_MARCH = 1'b1;

  // Geometry constants (Q16.16): shortest usable line and fallback step
  localparam logic [32:0] MIN_LEN      = 33'd66;
  localparam logic [30:0] DEFAULT_STEP = 31'd3277;

  // Shared serial arithmetic unit
  localparam int ARITH_A_W = 72;
  localparam int ARITH_B_W = 64;
  localparam int MUL_OP_W  = 36;
  localparam logic [1:0] ARITH_MUL  = 2'd0;
  localparam logic [1:0] ARITH_DIV  = 2'd1;
  localparam logic [1:0] ARITH_SQRT = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic               kind;
    logic [15:0]        cell_index;
    logic signed [7:0]  cell_cost;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] radius_cap;
  } olm_in_t;

  typedef struct packed {
    logic               found;
    logic               hit_edge;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        gap_to_goal;
  } olm_out_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [30:0]        cell_size;
    logic [6:0]         cost_limit;
    logic signed [31:0] clearance;
    logic [30:0]        min_goal_gap;
    logic [30:0]        step_length;
  } olm_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [1:0]           op;
    logic [ARITH_A_W-1:0] a;
    logic [ARITH_B_W-1:0] b;
  } olm_arith_req_t;

  typedef struct packed {
    logic                 done;
    logic [ARITH_A_W-1:0] q;
    logic [ARITH_B_W-1:0] r;
  } olm_arith_rsp_t;

endpackage

[hw/rtl/olm_arith.sv]
// Shared bit-serial multiplier, restoring divider and square root unit.
module olm_arith (
  input  logic                    clk,
  input  logic                    rst_n,
  input  olm_pkg::olm_arith_req_t req,
  output olm_pkg::olm_arith_rsp_t rsp
);
  import olm_pkg::*;

  localparam int CNT_W = $clog2(ARITH_A_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [1:0]       op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ARITH_A_W-1:0] acc_r;
  logic [ARITH_A_W-1:0] aux_r;
  logic [ARITH_B_W-1:0] b_r;
  logic [ARITH_B_W:0]   rem_r;

  logic [ARITH_B_W:0] div_sh;
  logic [ARITH_B_W:0] div_diff;
  logic               div_ge;
  logic [ARITH_B_W:0] sq_sh;
  logic [ARITH_B_W:0] sq_trial;
  logic               sq_ge;

  // One remainder step for division and for square root
  always_comb begin
    div_sh   = {rem_r[ARITH_B_W-1:0], acc_r[ARITH_A_W-1]};
    div_ge   = div_sh >= {1'b0, b_r};
    div_diff = div_sh - {1'b0, b_r};
    sq_sh    = {rem_r[ARITH_B_W-2:0], acc_r[ARITH_A_W-1 -: 2]};
    sq_trial = {aux_r[ARITH_B_W-2:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
  end

  // Control: busy flag, iteration count, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ARITH_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        if (req.op == ARITH_DIV) begin
          cnt_r <= CNT_W'(ARITH_A_W);
        end else begin
          cnt_r <= CNT_W'(MUL_OP_W);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.op)
        ARITH_MUL: begin
          acc_r <= '0;
          aux_r <= ARITH_A_W'(req.a[MUL_OP_W-1:0]);
          b_r   <= ARITH_B_W'(req.b[MUL_OP_W-1:0]);
        end
        ARITH_DIV: begin
          acc_r <= req.a;
          rem_r <= '0;
          b_r   <= req.b;
        end
        default: begin
          acc_r <= req.a;
          aux_r <= '0;
          rem_r <= '0;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        ARITH_MUL: begin
          if (b_r[0]) acc_r <= acc_r + aux_r;
          aux_r <= {aux_r[ARITH_A_W-2:0], 1'b0};
          b_r   <= {1'b0, b_r[ARITH_B_W-1:1]};
        end
        ARITH_DIV: begin
          rem_r <= div_ge ? div_diff : div_sh;
          acc_r <= {acc_r[ARITH_A_W-2:0], div_ge};
        end
        default: begin
          rem_r <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          aux_r <= {aux_r[ARITH_A_W-2:0], sq_ge};
          acc_r <= {acc_r[ARITH_A_W-3:0], 2'b00};
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = (op_r == ARITH_SQRT) ? aux_r : acc_r;
  assign rsp.r    = rem_r[ARITH_B_W-1:0];

endmodule

[hw/rtl/olm_fifo.sv]
// Short item queue between the front and the march engine.
module olm_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  olm_pkg::olm_in_t push_data,
  output logic             full,
  input  logic             pop,
  output olm_pkg::olm_in_t pop_data,
  output logic             empty
);
  import olm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  olm_in_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

[hw/rtl/olm_front.sv]
// Input side: takes items, drops writes outside the grid, queues the rest.
module olm_front #(
  parameter int GRID_W = olm_pkg::GRID_W_DEF,
  parameter int GRID_H = olm_pkg::GRID_H_DEF
) (
  input  logic             in_valid,
  output logic             in_ready,
  input  olm_pkg::olm_in_t in_data,
  input  logic             clear_busy,
  input  logic             q_full,
  output logic             q_push,
  output olm_pkg::olm_in_t q_data
);
  import olm_pkg::*;

  localparam longint CELLS = longint'(GRID_W) * longint'(GRID_H);

  logic keep;

  // A write beyond the grid changes nothing and is dropped here
  always_comb begin
    keep     = (in_data.kind == KIND_MARCH) || (26'(in_data.cell_index) < 26'(CELLS));
    in_ready = !q_full && !clear_busy;
    q_push   = in_valid && in_ready && keep;
    q_data   = in_data;
  end

endmodule

[hw/rtl/olm_back.sv]
// March engine: cost grid memory, line sampling and clearance disc test.
module olm_back #(
  parameter int GRID_W         = olm_pkg::GRID_W_DEF,
  parameter int GRID_H         = olm_pkg::GRID_H_DEF,
  parameter int MAX_SAMPLES    = olm_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_RING_CELLS = olm_pkg::MAX_RING_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  olm_pkg::olm_cfg_t       cfg,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  olm_pkg::olm_in_t        q_data,
  output olm_pkg::olm_arith_req_t arith_req,
  input  olm_pkg::olm_arith_rsp_t arith_rsp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output olm_pkg::olm_out_t       out_data,
  output logic                    clear_busy
);
  import olm_pkg::*;

  localparam longint CELLS     = longint'(GRID_W) * longint'(GRID_H);
  localparam int     MEM_DEPTH = (CELLS > 65536) ? 65536 : int'(CELLS);
  localparam int     AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int     K_W       = $clog2(MAX_SAMPLES + 2);
  localparam int     S_W       = 48;
  localparam int     IDX_W     = 25;

  // Sequencer states
  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_SQX   = 5'd2;
  localparam logic [4:0] ST_SQY   = 5'd3;
  localparam logic [4:0] ST_SQRT  = 5'd4;
  localparam logic [4:0] ST_RC    = 5'd5;
  localparam logic [4:0] ST_RSQ   = 5'd6;
  localparam logic [4:0] ST_BSQ   = 5'd7;
  localparam logic [4:0] ST_NLIM  = 5'd8;
  localparam logic [4:0] ST_CHK   = 5'd9;
  localparam logic [4:0] ST_MX    = 5'd10;
  localparam logic [4:0] ST_DX    = 5'd11;
  localparam logic [4:0] ST_MY    = 5'd12;
  localparam logic [4:0] ST_DY    = 5'd13;
  localparam logic [4:0] ST_FX    = 5'd14;
  localparam logic [4:0] ST_FY    = 5'd15;
  localparam logic [4:0] ST_DISC  = 5'd16;
  localparam logic [4:0] ST_RD    = 5'd17;
  localparam logic [4:0] ST_VERD  = 5'd18;
  localparam logic [4:0] ST_EMIT  = 5'd19;

  logic [4:0]  state_r, state_nxt;
  logic        wait_r, wait_nxt;
  logic [AW-1:0] clr_addr_r;
  logic        out_valid_r;
  olm_out_t    out_data_r;

  // March context
  logic signed [31:0] rx_r, ry_r, cap_r;
  logic               dxneg_r, dyneg_r;
  logic [32:0]        adx_r, ady_r;
  logic [ARITH_A_W-1:0] tmp_r;
  logic [ARITH_A_W-1:0] sq_r;
  logic [32:0]        len_r;
  logic [30:0]        res_r;
  logic [30:0]        step_r;
  logic [6:0]         r_r;
  logic [15:0]        nlim_r;
  logic [63:0]        rsq_r;
  logic [K_W-1:0]     k_r;
  logic [S_W-1:0]     s_r;
  logic [32:0]        rem_r;
  logic signed [31:0] sx_r, sy_r;
  logic signed [35:0] ccx_r, ccy_r;
  logic signed [7:0]  ddx_r, ddy_r;
  logic               ok_r, found_r, edge_r, entered_r;
  logic signed [31:0] px_r, py_r;
  logic [32:0]        gap_r;

  // Grid memory
  logic [7:0]    grid_mem [MEM_DEPTH];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] cell_addr;

  // Combinational helpers
  logic               arith_state, arith_done;
  logic signed [32:0] dx_in, dy_in;
  logic [30:0]        res_in;
  logic [30:0]        step_in;
  logic               clr_pos;
  logic [30:0]        clr;
  logic [32:0]        remc;
  logic               chk_end;
  logic signed [32:0] ax, ay;
  logic [32:0]        aabs;
  logic               aneg;
  logic signed [35:0] cc_new;
  logic signed [33:0] sx_new;
  logic signed [7:0]  rs;
  logic [15:0]        n;
  logic signed [35:0] cx, cy;
  logic               inb;
  logic [IDX_W-1:0]   idx;
  logic               cell_in;
  logic               cell_bad;
  logic               dd_last;
  logic signed [7:0]  ddx_adv, ddy_adv;
  logic               cap_ok;
  logic [30:0]        gap_sat;

  assign clear_busy = (state_r == ST_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Per-march and per-sample arithmetic glue
  always_comb begin
    dx_in   = {q_data.goal_x[31], q_data.goal_x} - {q_data.robot_x[31], q_data.robot_x};
    dy_in   = {q_data.goal_y[31], q_data.goal_y} - {q_data.robot_y[31], q_data.robot_y};
    res_in  = (cfg.cell_size == '0) ? 31'd1 : cfg.cell_size;
    step_in = (33'(cfg.step_length) > MIN_LEN) ? cfg.step_length : DEFAULT_STEP;
    clr_pos = !cfg.clearance[31] && (cfg.clearance != '0);
    clr     = cfg.clearance[30:0];
    remc    = len_r - s_r[32:0];
    chk_end = (k_r > K_W'(MAX_SAMPLES)) || (s_r >= S_W'(len_r)) ||
              (remc < 33'(cfg.min_goal_gap));
    // floor((p - origin) / cell) via magnitude division
    ax      = {sx_r[31], sx_r} - {cfg.origin_x[31], cfg.origin_x};
    ay      = {sy_r[31], sy_r} - {cfg.origin_y[31], cfg.origin_y};
    aneg    = (state_r == ST_FX) ? ax[32] : ay[32];
    aabs    = (state_r == ST_FX) ? (ax[32] ? 33'(-ax) : 33'(ax))
                                 : (ay[32] ? 33'(-ay) : 33'(ay));
    if (!aneg) begin
      cc_new = $signed(36'(arith_rsp.q[33:0]));
    end else if (arith_rsp.r != '0) begin
      cc_new = -$signed(36'(arith_rsp.q[33:0]) + 36'd1);
    end else begin
      cc_new = -$signed(36'(arith_rsp.q[33:0]));
    end
    // Sample position: robot plus signed offset
    if (state_r == ST_DX) begin
      sx_new = dxneg_r ? ($signed({{2{rx_r[31]}}, rx_r}) - $signed({1'b0, arith_rsp.q[32:0]}))
                       : ($signed({{2{rx_r[31]}}, rx_r}) + $signed({1'b0, arith_rsp.q[32:0]}));
    end else begin
      sx_new = dyneg_r ? ($signed({{2{ry_r[31]}}, ry_r}) - $signed({1'b0, arith_rsp.q[32:0]}))
                       : ($signed({{2{ry_r[31]}}, ry_r}) + $signed({1'b0, arith_rsp.q[32:0]}));
    end
  end

  // Disc walk: cell offset, bounds, address and next offset
  always_comb begin
    rs       = $signed({1'b0, r_r});
    n        = 16'(ddx_r * ddx_r) + 16'(ddy_r * ddy_r);
    cx       = ccx_r + 36'(ddx_r);
    cy       = ccy_r + 36'(ddy_r);
    inb      = !cx[35] && !cy[35] && (cx < 36'(GRID_W)) && (cy < 36'(GRID_H));
    idx      = IDX_W'(cy[11:0]) * IDX_W'(GRID_W) + IDX_W'(cx[11:0]);
    cell_in  = inb && (idx < IDX_W'(MEM_DEPTH));
    cell_addr = idx[AW-1:0];
    cell_bad = rd_data_r[7] || (rd_data_r[6:0] > cfg.cost_limit);
    dd_last  = (ddx_r == rs) && (ddy_r == rs);
    ddx_adv  = (ddx_r == rs) ? -rs : ddx_r + 8'sd1;
    ddy_adv  = (ddx_r == rs) ? ddy_r + 8'sd1 : ddy_r;
    cap_ok   = cap_r[31] || (cap_r == '0) || (rem_r <= {1'b0, cap_r});
    gap_sat  = gap_r[32:31] != 2'b00 ? 31'h7FFF_FFFF : gap_r[30:0];
  end

  // Requests to the shared arithmetic unit
  always_comb begin
    arith_state = 1'b1;
    arith_req.op = ARITH_MUL;
    arith_req.a  = '0;
    arith_req.b  = '0;
    case (state_r)
      ST_SQX: begin
        arith_req.a = ARITH_A_W'(adx_r);
        arith_req.b = ARITH_B_W'(adx_r);
      end
      ST_SQY: begin
        arith_req.a = ARITH_A_W'(ady_r);
        arith_req.b = ARITH_B_W'(ady_r);
      end
      ST_SQRT: begin
        arith_req.op = ARITH_SQRT;
        arith_req.a  = sq_r;
      end
      ST_RC: begin
        arith_req.op = ARITH_DIV;
        arith_req.a  = ARITH_A_W'(32'(clr) + 32'(res_r) - 32'd1);
        arith_req.b  = ARITH_B_W'(res_r);
      end
      ST_RSQ: begin
        arith_req.a = ARITH_A_W'(clr);
        arith_req.b = ARITH_B_W'(clr);
      end
      ST_BSQ: begin
        arith_req.a = ARITH_A_W'(res_r);
        arith_req.b = ARITH_B_W'(res_r);
      end
      ST_NLIM: begin
        arith_req.op = ARITH_DIV;
        arith_req.a  = ARITH_A_W'(rsq_r);
        arith_req.b  = tmp_r[ARITH_B_W-1:0];
      end
      ST_MX: begin
        arith_req.a = ARITH_A_W'(adx_r);
        arith_req.b = ARITH_B_W'(s_r[32:0]);
      end
      ST_MY: begin
        arith_req.a = ARITH_A_W'(ady_r);
        arith_req.b = ARITH_B_W'(s_r[32:0]);
      end
      ST_DX, ST_DY: begin
        arith_req.op = ARITH_DIV;
        arith_req.a  = tmp_r;
        arith_req.b  = ARITH_B_W'(len_r);
      end
      ST_FX, ST_FY: begin
        arith_req.op = ARITH_DIV;
        arith_req.a  = ARITH_A_W'(aabs);
        arith_req.b  = ARITH_B_W'(res_r);
      end
      default: arith_state = 1'b0;
    endcase
    arith_req.start = arith_state && !wait_r;
    arith_done      = arith_state && wait_r && arith_rsp.done;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    q_pop     = 1'b0;
    if (arith_state) wait_nxt = wait_r ? !arith_rsp.done : 1'b1;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == AW'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.kind == KIND_MARCH) state_nxt = ST_SQX;
        end
      end
      ST_SQX:  if (arith_done) state_nxt = ST_SQY;
      ST_SQY:  if (arith_done) state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (arith_done) begin
          if (arith_rsp.q[32:0] < MIN_LEN) begin
            state_nxt = ST_EMIT;
          end else if (!clr_pos) begin
            state_nxt = ST_CHK;
          end else begin
            state_nxt = ST_RC;
          end
        end
      end
      ST_RC:   if (arith_done) state_nxt = ST_RSQ;
      ST_RSQ:  if (arith_done) state_nxt = ST_BSQ;
      ST_BSQ:  if (arith_done) state_nxt = ST_NLIM;
      ST_NLIM: if (arith_done) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = chk_end ? ST_EMIT : ST_MX;
      ST_MX:   if (arith_done) state_nxt = ST_DX;
      ST_DX:   if (arith_done) state_nxt = ST_MY;
      ST_MY:   if (arith_done) state_nxt = ST_DY;
      ST_DY:   if (arith_done) state_nxt = ST_FX;
      ST_FX:   if (arith_done) state_nxt = ST_FY;
      ST_FY:   if (arith_done) state_nxt = ST_DISC;
      ST_DISC: begin
        if (n > nlim_r) begin
          if (dd_last) state_nxt = ST_VERD;
        end else if (!cell_in) begin
          state_nxt = ST_VERD;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (cell_bad || dd_last) begin
          state_nxt = ST_VERD;
        end else begin
          state_nxt = ST_DISC;
        end
      end
      ST_VERD: state_nxt = (!ok_r && entered_r) ? ST_EMIT : ST_CHK;
      ST_EMIT: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      wait_r      <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // March datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        rx_r      <= q_data.robot_x;
        ry_r      <= q_data.robot_y;
        cap_r     <= q_data.radius_cap;
        dxneg_r   <= dx_in[32];
        dyneg_r   <= dy_in[32];
        adx_r     <= dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
        ady_r     <= dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
        found_r   <= 1'b0;
        edge_r    <= 1'b0;
        entered_r <= 1'b0;
      end
      ST_SQX: if (arith_done) tmp_r <= arith_rsp.q;
      ST_SQY: if (arith_done) sq_r <= tmp_r + arith_rsp.q;
      ST_SQRT: begin
        if (arith_done) begin
          len_r  <= arith_rsp.q[32:0];
          res_r  <= res_in;
          step_r <= step_in;
          k_r    <= K_W'(1);
          s_r    <= S_W'(step_in);
          r_r    <= '0;
          nlim_r <= 16'hFFFF;
        end
      end
      ST_RC: begin
        if (arith_done) begin
          r_r <= (arith_rsp.q > ARITH_A_W'(MAX_RING_CELLS)) ? 7'(MAX_RING_CELLS)
                                                            : arith_rsp.q[6:0];
        end
      end
      ST_RSQ: if (arith_done) rsq_r <= arith_rsp.q[63:0];
      ST_BSQ: if (arith_done) tmp_r <= arith_rsp.q;
      ST_NLIM: begin
        if (arith_done) begin
          nlim_r <= (arith_rsp.q > ARITH_A_W'(16'hFFFF)) ? 16'hFFFF : arith_rsp.q[15:0];
        end
      end
      ST_CHK: rem_r <= remc;
      ST_MX:  if (arith_done) tmp_r <= arith_rsp.q;
      ST_DX:  if (arith_done) sx_r <= sx_new[31:0];
      ST_MY:  if (arith_done) tmp_r <= arith_rsp.q;
      ST_DY:  if (arith_done) sy_r <= sx_new[31:0];
      ST_FX:  if (arith_done) ccx_r <= cc_new;
      ST_FY: begin
        if (arith_done) begin
          ccy_r <= cc_new;
          ddx_r <= -rs;
          ddy_r <= -rs;
        end
      end
      ST_DISC: begin
        if (n > nlim_r) begin
          ddx_r <= ddx_adv;
          ddy_r <= ddy_adv;
          if (dd_last) ok_r <= 1'b1;
        end else if (!cell_in) begin
          ok_r <= 1'b0;
        end
      end
      ST_RD: begin
        if (cell_bad) begin
          ok_r <= 1'b0;
        end else begin
          ddx_r <= ddx_adv;
          ddy_r <= ddy_adv;
          if (dd_last) ok_r <= 1'b1;
        end
      end
      ST_VERD: begin
        k_r <= k_r + 1'b1;
        s_r <= s_r + S_W'(step_r);
        if (!ok_r) begin
          if (entered_r) edge_r <= 1'b1;
        end else begin
          entered_r <= 1'b1;
          if (cap_ok) begin
            found_r <= 1'b1;
            px_r    <= sx_r;
            py_r    <= sy_r;
            gap_r   <= rem_r;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_data_r.found       <= found_r;
          out_data_r.hit_edge    <= edge_r;
          out_data_r.point_x     <= found_r ? px_r : '0;
          out_data_r.point_y     <= found_r ? py_r : '0;
          out_data_r.gap_to_goal <= found_r ? gap_sat : '0;
        end
      end
      default: ;
    endcase
  end

  // Grid memory port: one write, one registered read
  always_comb begin
    mem_we    = (state_r == ST_CLEAR) ||
                (state_r == ST_IDLE && !q_empty && q_data.kind == KIND_WRITE);
    mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : q_data.cell_index[AW-1:0];
    mem_wdata = (state_r == ST_CLEAR) ? 8'hFF : q_data.cell_cost;
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= grid_mem[cell_addr];
  end

endmodule

[hw/rtl/occupancy_line_march_free_point.sv]
// Top level of the occupancy-grid line march that finds the nearest safe point.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   input   | in_valid / in_ready / in_data  | in
//   result  | out_valid / out_ready / out_data | out
//   config  | cfg_we / cfg_index / cfg_wdata | in
//
// A march first finds the line length and, when the clearance is positive, the
// disc radius and its limit; then for each sample it uses the shared serial
// multiply/divide unit and walks the disc cells, with one grid memory read for
// each cell inside the radius.
// After reset a clearing pass writes every grid memory entry unknown, one per
// cycle, min(GRID_W*GRID_H, 65536) entries, during which in_ready stays low.
// A stalled result leaves the engine waiting; the input queue keeps filling.
module occupancy_line_march_free_point #(
  parameter int GRID_W         = olm_pkg::GRID_W_DEF,
  parameter int GRID_H         = olm_pkg::GRID_H_DEF,
  parameter int MAX_SAMPLES    = olm_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_RING_CELLS = olm_pkg::MAX_RING_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  olm_pkg::olm_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output olm_pkg::olm_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [olm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [olm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import olm_pkg::*;

  olm_cfg_t       cfg_r;
  logic           clear_busy;
  logic           q_full, q_empty, q_push, q_pop;
  olm_in_t        q_in, q_out;
  olm_arith_req_t arith_req;
  olm_arith_rsp_t arith_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.cell_size    <= CELL_SIZE_RST;
      cfg_r.cost_limit   <= COST_LIMIT_RST;
      cfg_r.clearance    <= CLEARANCE_RST;
      cfg_r.min_goal_gap <= MIN_GOAL_GAP_RST;
      cfg_r.step_length  <= STEP_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:     cfg_r.origin_x     <= cfg_wdata;
        CFG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_wdata;
        CFG_CELL_SIZE:    cfg_r.cell_size    <= cfg_wdata[30:0];
        CFG_COST_LIMIT:   cfg_r.cost_limit   <= cfg_wdata[6:0];
        CFG_CLEARANCE:    cfg_r.clearance    <= cfg_wdata;
        CFG_MIN_GOAL_GAP: cfg_r.min_goal_gap <= cfg_wdata[30:0];
        CFG_STEP_LENGTH:  cfg_r.step_length  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  olm_front #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  olm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  olm_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  olm_back #(
    .GRID_W         (GRID_W),
    .GRID_H         (GRID_H),
    .MAX_SAMPLES    (MAX_SAMPLES),
    .MAX_RING_CELLS (MAX_RING_CELLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_out),
    .arith_req  (arith_req),
    .arith_rsp  (arith_rsp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .clear_busy (clear_busy)
  );

  // No transfer in while the grid is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_ready)
    else $error("input taken during grid clear");

  // Results only come after the clearing pass
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !out_valid)
    else $error("result during grid clear");

  // A miss carries a zero point and gap
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |->
      (out_data.point_x == '0 && out_data.point_y == '0 && out_data.gap_to_goal == '0))
    else $error("miss result with nonzero payload");

endmodule
